### sv/bkht_pkg.sv
package bkht_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [2:0] CFG_BRICKS_X = 3'd0;
  localparam logic [2:0] CFG_BRICKS_Y = 3'd1;
  localparam logic [2:0] CFG_BRICKS_Z = 3'd2;
  localparam logic [2:0] CFG_SLOTS    = 3'd3;
  localparam logic [2:0] CFG_LIMIT    = 3'd4;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quotient;
    logic [DataW-1:0] remainder;
  } div_rsp_t;

endpackage

### sv/bkht_div.sv
module bkht_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bkht_pkg::div_req_t req_i,
  output bkht_pkg::div_rsp_t rsp_o
);
  import bkht_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [5:0]       cnt_q;
  logic [DataW-1:0] rem_q;
  logic [DataW-1:0] quo_q;
  logic [DataW-1:0] div_q;
  logic             bzero_q;
  logic [DataW:0]   rem_sh;
  logic [DataW:0]   diff;
  logic             ge;

  // One restoring step per cycle; a zero divisor leaves the dividend as remainder.
  always_comb begin
    rem_sh = {rem_q, quo_q[DataW-1]};
    diff   = rem_sh - {1'b0, div_q};
    ge     = rem_sh >= {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 6'(DataW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q   <= '0;
      quo_q   <= req_i.dividend;
      div_q   <= req_i.divisor;
      bzero_q <= (req_i.divisor == '0);
    end else if (busy_q) begin
      rem_q <= ge ? diff[DataW-1:0] : rem_sh[DataW-1:0];
      quo_q <= {quo_q[DataW-2:0], ge};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = bzero_q ? '0 : quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

### sv/brick_request_hash_table_core.sv
// Insert: the key is built in the multiply steps and reduced by the modulo divider;
// each probe is one read of the slot memory, then one check and write back.
// Read: radix multiplies, a slot read and check, then three divisions if it is used.
// Clear: one slot per cycle over every slot. One request is worked on at a time.
// After reset the table is swept empty with busy_o high.
// Each result shows for one cycle on done_o; the receiver cannot stall it.
module brick_request_hash_table_core #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [8:0]  brick_x_i,
  input  logic [8:0]  brick_y_i,
  input  logic [8:0]  brick_z_i,
  input  logic [3:0]  detail_level_i,
  input  logic [11:0] slot_index_i,
  output logic        done_o,
  output logic [7:0]  probes_used_o,
  output logic        slot_used_o,
  output logic [8:0]  found_x_o,
  output logic [8:0]  found_y_o,
  output logic [8:0]  found_z_o,
  output logic [3:0]  found_level_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);
  import bkht_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam logic [DataW-1:0] DepthW = DataW'(TABLE_DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(TABLE_DEPTH - 1);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_CLEAR   = 11'b000_0000_0010,
    ST_MUL     = 11'b000_0000_0100,
    ST_DIV_KEY = 11'b000_0000_1000,
    ST_PRB_RD  = 11'b000_0001_0000,
    ST_PRB_CHK = 11'b000_0010_0000,
    ST_DEC_RD  = 11'b000_0100_0000,
    ST_DEC_CHK = 11'b000_1000_0000,
    ST_DIV_W   = 11'b001_0000_0000,
    ST_DIV_Z   = 11'b010_0000_0000,
    ST_DIV_Y   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic [2:0]  step_q, step_d;
  logic [AW-1:0] clr_q, clr_d;
  logic        report_q, report_d;
  logic        done_q, done_d;
  logic [9:0]  rx_q, rx_d, ry_q, ry_d, rz_q, rz_d;
  logic [12:0] slots_q, slots_d;
  logic [7:0]  limit_q, limit_d;

  logic [1:0]  act_q, act_d;
  logic [8:0]  bx_q, bx_d, by_q, by_d, bz_q, bz_d;
  logic [3:0]  lv_q, lv_d;
  logic [11:0] idx_q, idx_d;
  logic [DataW-1:0] rxy_q, rxy_d, vol_q, vol_d, key_q, key_d, sum_q, sum_d;
  logic [DataW-1:0] w_q, w_d, z_q, z_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [7:0]  n_q, n_d;
  logic [7:0]  probes_q, probes_d;
  logic        used_q, used_d;
  logic [8:0]  fx_q, fx_d, fy_q, fy_d, fz_q, fz_d;
  logic [3:0]  fl_q, fl_d;

  div_req_t div_req_q, div_req_d;
  div_rsp_t div_rsp;

  logic [DataW-1:0] mem_q [TABLE_DEPTH];
  logic [DataW-1:0] rdata_q;
  logic [AW-1:0]    raddr, waddr;
  logic [DataW-1:0] wdata;
  logic             we;

  logic [DataW-1:0] mul_a, mul_b, mul_p;
  logic [DataW-1:0] m_eff, idx_ext, slots_ext, pos_inc;
  logic [8:0]       n_inc;
  logic             idx_oob;

  bkht_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    slots_ext = DataW'(slots_q);
    if (slots_ext == '0) begin
      m_eff = DataW'(1);
    end else if (slots_ext > DepthW) begin
      m_eff = DepthW;
    end else begin
      m_eff = slots_ext;
    end
    idx_ext = DataW'(idx_q);
    idx_oob = idx_ext >= DepthW;
    pos_inc = DataW'(pos_q) + DataW'(1);
    n_inc   = {1'b0, n_q} + 9'd1;

    case (step_q)
      3'd0:    begin mul_a = DataW'(rx_q); mul_b = DataW'(ry_q); end
      3'd1:    begin mul_a = rxy_q;        mul_b = DataW'(rz_q); end
      3'd2:    begin mul_a = DataW'(by_q); mul_b = DataW'(rx_q); end
      3'd3:    begin mul_a = DataW'(bz_q); mul_b = rxy_q;        end
      default: begin mul_a = DataW'(lv_q); mul_b = vol_q;        end
    endcase
    mul_p = mul_a * mul_b;

    raddr = (state_q == ST_DEC_RD) ? idx_ext[AW-1:0] : pos_q;
    we    = (state_q == ST_CLEAR) || ((state_q == ST_PRB_CHK) && (rdata_q == '0));
    waddr = (state_q == ST_CLEAR) ? clr_q : pos_q;
    wdata = (state_q == ST_CLEAR) ? '0 : key_q;
  end

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    clr_d    = clr_q;
    report_d = report_q;
    done_d   = 1'b0;
    rx_d     = rx_q;
    ry_d     = ry_q;
    rz_d     = rz_q;
    slots_d  = slots_q;
    limit_d  = limit_q;
    act_d    = act_q;
    bx_d     = bx_q;
    by_d     = by_q;
    bz_d     = bz_q;
    lv_d     = lv_q;
    idx_d    = idx_q;
    rxy_d    = rxy_q;
    vol_d    = vol_q;
    key_d    = key_q;
    sum_d    = sum_q;
    w_d      = w_q;
    z_d      = z_q;
    pos_d    = pos_q;
    n_d      = n_q;
    probes_d = probes_q;
    used_d   = used_q;
    fx_d     = fx_q;
    fy_d     = fy_q;
    fz_d     = fz_q;
    fl_d     = fl_q;
    div_req_d       = div_req_q;
    div_req_d.start = 1'b0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BRICKS_X: rx_d    = cfg_data_i[9:0];
        CFG_BRICKS_Y: ry_d    = cfg_data_i[9:0];
        CFG_BRICKS_Z: rz_d    = cfg_data_i[9:0];
        CFG_SLOTS:    slots_d = cfg_data_i;
        CFG_LIMIT:    limit_d = cfg_data_i[7:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          act_d  = action_i;
          bx_d   = brick_x_i;
          by_d   = brick_y_i;
          bz_d   = brick_z_i;
          lv_d   = detail_level_i;
          idx_d  = slot_index_i;
          step_d = 3'd0;
          unique case (action_i) inside
            ACT_INSERT, ACT_READ: state_d = ST_MUL;
            ACT_CLEAR: begin
              clr_d    = '0;
              report_d = 1'b1;
              state_d  = ST_CLEAR;
            end
            default: begin
              done_d   = 1'b1;
              probes_d = '0;
              used_d   = 1'b0;
              fx_d     = '0;
              fy_d     = '0;
              fz_d     = '0;
              fl_d     = '0;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == LastSlot) begin
          state_d = ST_IDLE;
          if (report_q) begin
            done_d   = 1'b1;
            probes_d = '0;
            used_d   = 1'b0;
            fx_d     = '0;
            fy_d     = '0;
            fz_d     = '0;
            fl_d     = '0;
          end
        end
      end
      ST_MUL: begin
        step_d = step_q + 3'd1;
        case (step_q)
          3'd0: rxy_d = mul_p;
          3'd1: begin
            vol_d = mul_p;
            if (act_q == ACT_READ) begin
              state_d = ST_DEC_RD;
            end
          end
          3'd2: key_d = DataW'(1) + DataW'(bx_q) + mul_p;
          3'd3: key_d = key_q + mul_p;
          default: begin
            key_d              = key_q + mul_p;
            div_req_d.start    = 1'b1;
            div_req_d.dividend = key_q + mul_p;
            div_req_d.divisor  = m_eff;
            state_d            = ST_DIV_KEY;
          end
        endcase
      end
      ST_DIV_KEY: begin
        if (div_rsp.done) begin
          pos_d   = div_rsp.remainder[AW-1:0];
          sum_d   = key_q;
          n_d     = '0;
          state_d = ST_PRB_RD;
        end
      end
      ST_PRB_RD: state_d = ST_PRB_CHK;
      ST_PRB_CHK: begin
        if ((rdata_q == '0) || (rdata_q == key_q)) begin
          done_d   = 1'b1;
          probes_d = n_q;
          used_d   = 1'b0;
          fx_d     = '0;
          fy_d     = '0;
          fz_d     = '0;
          fl_d     = '0;
          state_d  = ST_IDLE;
        end else if (n_inc < {1'b0, limit_q}) begin
          n_d   = n_inc[7:0];
          sum_d = sum_q + DataW'(1);
          // The probe sum wraps to zero, which restarts the walk at slot zero.
          if ((sum_q == '1) || (pos_inc == m_eff)) begin
            pos_d = '0;
          end else begin
            pos_d = pos_inc[AW-1:0];
          end
          state_d = ST_PRB_RD;
        end else begin
          done_d   = 1'b1;
          probes_d = limit_q;
          used_d   = 1'b0;
          fx_d     = '0;
          fy_d     = '0;
          fz_d     = '0;
          fl_d     = '0;
          state_d  = ST_IDLE;
        end
      end
      ST_DEC_RD: state_d = ST_DEC_CHK;
      ST_DEC_CHK: begin
        if (idx_oob || (rdata_q == '0)) begin
          done_d   = 1'b1;
          probes_d = '0;
          used_d   = 1'b0;
          fx_d     = '0;
          fy_d     = '0;
          fz_d     = '0;
          fl_d     = '0;
          state_d  = ST_IDLE;
        end else begin
          div_req_d.start    = 1'b1;
          div_req_d.dividend = rdata_q - DataW'(1);
          div_req_d.divisor  = vol_q;
          state_d            = ST_DIV_W;
        end
      end
      ST_DIV_W: begin
        if (div_rsp.done) begin
          w_d                = div_rsp.quotient;
          div_req_d.start    = 1'b1;
          div_req_d.dividend = div_rsp.remainder;
          div_req_d.divisor  = rxy_q;
          state_d            = ST_DIV_Z;
        end
      end
      ST_DIV_Z: begin
        if (div_rsp.done) begin
          z_d                = div_rsp.quotient;
          div_req_d.start    = 1'b1;
          div_req_d.dividend = div_rsp.remainder;
          div_req_d.divisor  = DataW'(rx_q);
          state_d            = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (div_rsp.done) begin
          done_d   = 1'b1;
          probes_d = '0;
          used_d   = 1'b1;
          fx_d     = div_rsp.remainder[8:0];
          fy_d     = div_rsp.quotient[8:0];
          fz_d     = z_q[8:0];
          fl_d     = w_q[3:0];
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      step_q    <= '0;
      clr_q     <= '0;
      report_q  <= 1'b0;
      done_q    <= 1'b0;
      rx_q      <= 10'd1;
      ry_q      <= 10'd1;
      rz_q      <= 10'd1;
      slots_q   <= 13'd4096;
      limit_q   <= 8'd8;
      div_req_q <= '0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      clr_q     <= clr_d;
      report_q  <= report_d;
      done_q    <= done_d;
      rx_q      <= rx_d;
      ry_q      <= ry_d;
      rz_q      <= rz_d;
      slots_q   <= slots_d;
      limit_q   <= limit_d;
      div_req_q <= div_req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    bx_q  <= bx_d;
    by_q  <= by_d;
    bz_q  <= bz_d;
    lv_q  <= lv_d;
    idx_q <= idx_d;
    rxy_q <= rxy_d;
    vol_q <= vol_d;
    key_q <= key_d;
    sum_q <= sum_d;
    w_q   <= w_d;
    z_q   <= z_d;
    pos_q <= pos_d;
    n_q   <= n_d;
    probes_q <= probes_d;
    used_q   <= used_d;
    fx_q     <= fx_d;
    fy_q     <= fy_d;
    fz_q     <= fz_d;
    fl_q     <= fl_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign done_o        = done_q;
  assign probes_used_o = probes_q;
  assign slot_used_o   = used_q;
  assign found_x_o     = fx_q;
  assign found_y_o     = fy_q;
  assign found_z_o     = fz_q;
  assign found_level_o = fl_q;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bkht_pkg::*;

  localparam int unsigned Depth = 4096;

  typedef struct {
    logic [1:0]  act;
    logic [8:0]  bx;
    logic [8:0]  by;
    logic [8:0]  bz;
    logic [3:0]  lv;
    logic [11:0] idx;
  } brick_req_t;

  typedef struct {
    logic [7:0] probes;
    logic       used;
    logic [8:0] fx;
    logic [8:0] fy;
    logic [8:0] fz;
    logic [3:0] flv;
  } brick_rsp_t;

  class hash_scoreboard;
    int unsigned slot_key[Depth];
    int unsigned radix_x = 1, radix_y = 1, radix_z = 1, slot_count = 4096, limit = 8;
    brick_rsp_t  expected_rsp[$];
    int          errors = 0;

    function void set_reg(logic [2:0] idx, logic [12:0] data);
      case (idx)
        CFG_BRICKS_X: radix_x = 32'(data[9:0]);
        CFG_BRICKS_Y: radix_y = 32'(data[9:0]);
        CFG_BRICKS_Z: radix_z = 32'(data[9:0]);
        CFG_SLOTS:    slot_count = 32'(data);
        CFG_LIMIT:    limit = 32'(data[7:0]);
        default: ;
      endcase
    endfunction

    function int unsigned modulus();
      if (slot_count == 0) return 1;
      if (slot_count > Depth) return Depth;
      return slot_count;
    endfunction

    function void note(brick_req_t r);
      brick_rsp_t  e;
      int unsigned rxy, vol, key, m, n, pos, held, v, w, z, y;
      e = '{default: '0};
      rxy = radix_x * radix_y;
      vol = rxy * radix_z;
      if (r.act == ACT_INSERT) begin
        key = 1 + r.bx + r.by * radix_x + r.bz * rxy + r.lv * vol;
        m = modulus();
        n = 0;
        e.probes = limit[7:0];
        do begin
          pos = (key + n) % m;
          held = slot_key[pos];
          if (held == 0) slot_key[pos] = key;
          if (held == 0 || held == key) begin
            e.probes = n[7:0];
            break;
          end
          n++;
        end while (n < limit);
      end else if (r.act == ACT_READ) begin
        v = slot_key[r.idx];
        if (v != 0) begin
          v = v - 1;
          w = (vol == 0) ? 0 : v / vol;
          v -= w * vol;
          z = (rxy == 0) ? 0 : v / rxy;
          v -= z * rxy;
          y = (radix_x == 0) ? 0 : v / radix_x;
          v -= y * radix_x;
          e.used = 1'b1;
          e.fx = v[8:0];
          e.fy = y[8:0];
          e.fz = z[8:0];
          e.flv = w[3:0];
        end
      end else if (r.act == ACT_CLEAR) begin
        foreach (slot_key[i]) slot_key[i] = 0;
      end
      expected_rsp = {expected_rsp, e};
    endfunction

    function void check(brick_rsp_t got);
      brick_rsp_t e;
      if (expected_rsp.size() == 0) begin
        $display("%0t: result with nothing expected, got %p", $realtime, got);
        errors++;
        return;
      end
      e = expected_rsp.pop_front();
      if (got.probes !== e.probes || got.used !== e.used || got.fx !== e.fx ||
          got.fy !== e.fy || got.fz !== e.fz || got.flv !== e.flv) begin
        $display("%0t: mismatch, expected %p, actual %p", $realtime, e, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  action_i = '0;
  logic [8:0]  brick_x_i = '0, brick_y_i = '0, brick_z_i = '0;
  logic [3:0]  detail_level_i = '0;
  logic [11:0] slot_index_i = '0;
  logic        done_o;
  logic [7:0]  probes_used_o;
  logic        slot_used_o;
  logic [8:0]  found_x_o, found_y_o, found_z_o;
  logic [3:0]  found_level_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [12:0] cfg_data_i = '0;

  hash_scoreboard sb = new();

  brick_request_hash_table_core #(.TABLE_DEPTH(Depth)) DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check('{probes_used_o, slot_used_o, found_x_o, found_y_o, found_z_o, found_level_o});
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  // Start is always lowered at acceptance.
  task automatic send_req(brick_req_t r, int gap);
    repeat (gap) @(posedge clk_i);
    @(posedge clk_i);
    action_i <= r.act;
    brick_x_i <= r.bx;
    brick_y_i <= r.by;
    brick_z_i <= r.bz;
    detail_level_i <= r.lv;
    slot_index_i <= r.idx;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    sb.note(r);
    start_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.expected_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [12:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic setup(int x, int y, int z, int slots, int lim);
    wait_drained();
    write_reg(CFG_BRICKS_X, 13'(x));
    write_reg(CFG_BRICKS_Y, 13'(y));
    write_reg(CFG_BRICKS_Z, 13'(z));
    write_reg(CFG_SLOTS, 13'(slots));
    write_reg(CFG_LIMIT, 13'(lim));
  endtask

  function automatic brick_req_t mk(logic [1:0] a, int x, int y, int z, int lv, int idx);
    brick_req_t r;
    r = '{a, 9'(x), 9'(y), 9'(z), 4'(lv), 12'(idx)};
    return r;
  endfunction

  function automatic int below(int radix);
    if (radix == 0) return $urandom_range(0, 511);
    return $urandom_range(0, (radix > 512 ? 512 : radix) - 1);
  endfunction

  function automatic brick_req_t random_req();
    brick_req_t r;
    int         pick;
    pick = $urandom_range(0, 99);
    r = mk(ACT_READ, $urandom_range(0, 511), $urandom_range(0, 511),
           $urandom_range(0, 511), $urandom_range(0, 15), $urandom_range(0, 4095));
    if (pick < 58) begin
      r.act = ACT_INSERT;
      if ($urandom_range(0, 4) != 0) begin
        r.bx = 9'(below(sb.radix_x));
        r.by = 9'(below(sb.radix_y));
        r.bz = 9'(below(sb.radix_z));
        r.lv = 4'($urandom_range(0, 3));
      end
    end else if (pick < 95) begin
      if ($urandom_range(0, 4) != 0) r.idx = 12'($urandom_range(0, sb.modulus() - 1));
    end else if (pick < 97) begin
      r.act = ACT_CLEAR;
    end else begin
      r.act = ACT_UNUSED;
    end
    return r;
  endfunction

  int setups[6][5] = '{
    '{8, 8, 4, 64, 255}, '{1023, 1023, 1023, 16, 4}, '{512, 512, 512, 8191, 8},
    '{3, 5, 7, 1, 255}, '{1, 1, 1, 37, 0}, '{20, 0, 9, 100, 2}
  };

  initial begin
    int unsigned rxy, vol, rem;
    int          hit_z, hit_x, hit_y, hit_bz, hit_lv, gap, burst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full radices: extreme bricks, a duplicate, reads, unused action and clear.
    setup(512, 512, 512, 4096, 8);
    send_req(mk(ACT_INSERT, 0, 0, 0, 0, 0), 0);
    send_req(mk(ACT_INSERT, 511, 511, 511, 15, 4095), 0);
    send_req(mk(ACT_INSERT, 511, 511, 511, 15, 0), 3);
    send_req(mk(ACT_READ, 0, 0, 0, 0, 1), 0);
    send_req(mk(ACT_READ, 511, 511, 511, 15, 0), 0);
    send_req(mk(ACT_READ, 0, 0, 0, 0, 4095), 1);
    send_req(mk(ACT_UNUSED, 511, 511, 511, 15, 4095), 0);
    send_req(mk(ACT_CLEAR, 0, 0, 0, 0, 0), 0);
    send_req(mk(ACT_READ, 0, 0, 0, 0, 0), 0);

    // A slot count of zero acts as one slot; a zero limit still probes once.
    setup(1, 1, 1, 0, 0);
    send_req(mk(ACT_INSERT, 5, 0, 0, 0, 0), 0);
    send_req(mk(ACT_INSERT, 6, 0, 0, 0, 0), 0);
    send_req(mk(ACT_READ, 0, 0, 0, 0, 0), 0);

    // Zero radix along x makes the decode divide by zero.
    setup(0, 7, 3, 4096, 1);
    send_req(mk(ACT_INSERT, 300, 2, 1, 9, 0), 0);
    send_req(mk(ACT_READ, 0, 0, 0, 0, 301), 0);

    // Search for a brick whose key wraps to zero.
    hit_z = -1;
    rxy = 1023 * 1023;
    for (int zc = 1023; zc > 900 && hit_z < 0; zc--) begin
      vol = rxy * zc;
      for (int lv = 0; lv < 16 && hit_z < 0; lv++)
        for (int bz = 0; bz < 512 && hit_z < 0; bz++) begin
          rem = 0 - (1 + lv * vol + bz * rxy);
          if (rem < 523264 && rem % 1023 <= 511 && rem / 1023 <= 511) begin
            hit_z = zc;
            hit_lv = lv;
            hit_bz = bz;
            hit_x = rem % 1023;
            hit_y = rem / 1023;
          end
        end
    end
    if (hit_z >= 0) begin
      setup(1023, 1023, hit_z, 8191, 3);
      send_req(mk(ACT_INSERT, hit_x, hit_y, hit_bz, hit_lv, 0), 0);
      send_req(mk(ACT_READ, 0, 0, 0, 0, 0), 0);
    end

    for (int p = 0; p < 6; p++) begin
      setup(setups[p][0], setups[p][1], setups[p][2], setups[p][3], setups[p][4]);
      burst = 0;
      for (int k = 0; k < 72; k++) begin
        if (burst > 0) begin
          burst--;
          gap = 0;
        end else if ($urandom_range(0, 9) == 0) begin
          burst = $urandom_range(4, 12);
          gap = 0;
        end else begin
          gap = $urandom_range(0, 17);
        end
        if ($urandom_range(0, 29) == 0) wait_drained();
        send_req(random_req(), gap);
      end
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_rsp.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
sv/bkht_pkg.sv
sv/bkht_div.sv
sv/brick_request_hash_table_core.sv
bench/testbench.sv
